### rtl/assert_macros.svh
// Assertion macros used by the checker file, bspe_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with an active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same, without a reset disable.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/bspe_pkg.sv
// Package for the posterior/entropy block: constants, log table function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bspe_pkg;
    localparam int MAX_HYP_DEF   = 16;
    localparam int LOG_BITS_DEF  = 8;
    localparam int PW            = 17;
    localparam int EW            = 19;
    localparam int SUMW          = 24;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [18:0] ENTROPY_MAX = 19'd458752;

    // Commands from controller to datapath.
    typedef enum logic [2:0] {
        CMD_NONE, CMD_LOAD, CMD_PREP, CMD_DIV_START, CMD_EMIT, CMD_CLEAR
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [5:0] idx;
        logic       last;
    } t_ctl;

    typedef struct packed {
        logic div_done;
    } t_sts;

    // floor(log2(1 + i/2^t) * 65536) by repeated squaring; used at elaboration.
    function automatic logic [15:0] log_entry(input int t, input int i);
        logic [63:0] z;
        logic [15:0] r;
        z = (64'(1 << t) + 64'(i)) << (30 - t);
        r = '0;
        for (int k = 0; k < 16; k++) begin
            z = (z * z) >> 30;
            r = {r[14:0], 1'b0};
            if (z >= 64'h8000_0000) begin
                r[0] = 1'b1;
                z = z >> 1;
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/binary_split_posterior_entropy.sv
// Bayesian posterior update with entropy: top level. A transaction is taken when
// start is high and busy is low, one hypothesis per cycle while loading; the
// hypothesis marked last starts the compute and busy stays high until the run
// is done. The receiver cannot stall: each result is shown for one cycle with
// o_valid. After the last load come a prep state, then for each result a read,
// a divider start, a wait on the two 33-step radix-2 dividers that run in
// parallel, one per posterior, and an emit, then a clear state before the next
// load. Depends on bspe_pkg, bspe_ctrl, bspe_datapath.
`timescale 1ns / 1ps
`default_nettype none
module binary_split_posterior_entropy
    import bspe_pkg::*;
#(
    parameter int MAX_HYPOTHESES = MAX_HYP_DEF,
    parameter int LOG_TABLE_BITS = LOG_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [16:0] i_prior_prob,
    input  wire logic [16:0] i_hit_likelihood,
    input  wire logic        i_last_hypothesis,
    output logic             o_valid,
    output logic [5:0]       o_hyp_index,
    output logic [16:0]      o_posterior_miss,
    output logic [16:0]      o_posterior_hit,
    output logic [16:0]      o_prob_miss,
    output logic [16:0]      o_prob_hit,
    output logic [18:0]      o_entropy_miss,
    output logic [18:0]      o_entropy_hit,
    output logic             o_zero_mass,
    output logic             o_last_result
);
    t_ctl ctl;
    t_sts sts;
    bspe_ctrl #(.MAX_HYPOTHESES(MAX_HYPOTHESES)) u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_last(i_last_hypothesis),
        .i_sts(sts), .o_busy(busy), .o_ctl(ctl));
    bspe_datapath #(.MAX_HYPOTHESES(MAX_HYPOTHESES), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_ctl(ctl), .i_prior_prob, .i_hit_likelihood,
        .o_sts(sts), .o_valid, .o_hyp_index, .o_posterior_miss, .o_posterior_hit,
        .o_prob_miss, .o_prob_hit, .o_entropy_miss, .o_entropy_hit,
        .o_zero_mass, .o_last_result);
endmodule
`default_nettype wire

### rtl/bspe_divider.sv
// Restoring radix-2 divider: floor((num << 16) / den), 33-bit quotient.
// Depends on bspe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bspe_divider
    import bspe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [16:0]        i_num,
    input  wire logic [SUMW-1:0]    i_den,
    output logic                    o_done,
    output logic [32:0]             o_quot
);
    localparam int QW = 33;
    logic [QW-1:0]   r_dvd;
    logic [SUMW:0]   r_rem;
    logic [5:0]      r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [SUMW:0]   n_trial;
    logic [SUMW:0]   n_shift;

    assign n_shift = {r_rem[SUMW-1:0], r_dvd[QW-1]};
    assign n_trial = n_shift - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QW);
                r_rem  <= '0;
                r_dvd  <= {i_num, 16'd0};
            end else if (r_busy) begin
                if (!n_trial[SUMW]) begin
                    r_rem <= n_trial;
                    r_dvd <= {r_dvd[QW-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_dvd <= {r_dvd[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_dvd;
endmodule
`default_nettype wire

### rtl/bspe_datapath.sv
// Datapath: hypothesis stores, joint sum, two dividers, entropy terms, result regs.
// Depends on bspe_pkg and bspe_divider.
`timescale 1ns / 1ps
`default_nettype none
module bspe_datapath
    import bspe_pkg::*;
#(
    parameter int MAX_HYPOTHESES = MAX_HYP_DEF,
    parameter int LOG_TABLE_BITS = LOG_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_ctl          i_ctl,
    input  wire logic [16:0]   i_prior_prob,
    input  wire logic [16:0]   i_hit_likelihood,
    output t_sts               o_sts,
    output logic               o_valid,
    output logic [5:0]         o_hyp_index,
    output logic [16:0]        o_posterior_miss,
    output logic [16:0]        o_posterior_hit,
    output logic [16:0]        o_prob_miss,
    output logic [16:0]        o_prob_hit,
    output logic [18:0]        o_entropy_miss,
    output logic [18:0]        o_entropy_hit,
    output logic               o_zero_mass,
    output logic               o_last_result
);
    localparam int AW = (MAX_HYPOTHESES > 1) ? $clog2(MAX_HYPOTHESES) : 1;
    localparam int T  = LOG_TABLE_BITS;
    localparam int TN = 1 << T;

    logic [16:0] r_prior_mem [MAX_HYPOTHESES];
    logic [16:0] r_joint_mem [MAX_HYPOTHESES];
    logic [16:0] r_prior_rd, r_joint_rd;
    logic [SUMW-1:0] r_sum;
    logic [16:0] r_p0, r_ph;
    logic        r_zm;
    logic [SUMW-1:0] r_acc_m, r_acc_h;
    logic [15:0] lt [TN];

    // Constant log table.
    always_comb begin
        for (int i = 0; i < TN; i++) lt[i] = log_entry(T, i);
    end

    logic [16:0] n_prior, n_psi, n_joint;
    logic [34:0] n_prod;
    assign n_prior = (i_prior_prob > ONE_Q16) ? ONE_Q16 : i_prior_prob;
    assign n_psi   = (i_hit_likelihood > ONE_Q16) ? ONE_Q16 : i_hit_likelihood;
    assign n_prod  = 35'(n_prior) * 35'(n_psi) + 35'd32768;
    assign n_joint = (n_prod[34:16] > 19'(n_prior)) ? n_prior : n_prod[32:16];

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == CMD_LOAD) begin
            r_prior_mem[i_ctl.idx[AW-1:0]] <= n_prior;
            r_joint_mem[i_ctl.idx[AW-1:0]] <= n_joint;
        end
        r_prior_rd <= r_prior_mem[i_ctl.idx[AW-1:0]];
        r_joint_rd <= r_joint_mem[i_ctl.idx[AW-1:0]];
    end

    // Dividers.
    logic        n_dstart, dm_done, dh_done;
    logic [32:0] qm, qh;
    logic [16:0] n_num;
    assign n_dstart = (i_ctl.cmd == CMD_DIV_START);
    assign n_num = (r_prior_rd >= r_joint_rd) ? r_prior_rd - r_joint_rd : '0;
    bspe_divider u_div_m (.i_clk, .i_rst_n, .i_start(n_dstart), .i_num(n_num),
        .i_den(SUMW'(r_p0)), .o_done(dm_done), .o_quot(qm));
    bspe_divider u_div_h (.i_clk, .i_rst_n, .i_start(n_dstart), .i_num(r_joint_rd),
        .i_den(r_sum), .o_done(dh_done), .o_quot(qh));
    assign o_sts.div_done = dh_done;

    // Entropy term: leading one, table lookup, multiply.
    function automatic logic [SUMW-1:0] term(input logic [16:0] x,
                                             input logic [15:0] ltab [TN]);
        logic [4:0]  b;
        logic [16:0] f;
        logic [T-1:0] idx;
        logic [20:0] nlog;
        logic [37:0] p;
        b = '0;
        for (int k = 0; k < 17; k++) if (x[k]) b = 5'(k);
        f = x & ~(17'd1 << b);
        if (int'(b) >= T) idx = T'(f >> (b - 5'(T)));
        else idx = T'(f << (5'(T) - b));
        nlog = {5'(5'd16 - b), 16'd0} - 21'(ltab[idx]);
        p = 38'(x) * 38'(nlog);
        term = (x == '0) ? '0 : SUMW'(p >> 16);
    endfunction

    logic [16:0] n_pm, n_pt;
    assign n_pm = (r_p0 == '0) ? '0 : ((qm > 33'(ONE_Q16)) ? ONE_Q16 : qm[16:0]);
    assign n_pt = (r_sum == '0) ? '0 : ((qh > 33'(ONE_Q16)) ? ONE_Q16 : qh[16:0]);

    // Running entropy sums including the result being emitted.
    logic [SUMW-1:0] n_tm, n_th;
    assign n_tm = r_acc_m + term(n_pm, lt);
    assign n_th = r_acc_h + term(n_pt, lt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_acc_m <= '0;
            r_acc_h <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (i_ctl.cmd)
                CMD_LOAD: r_sum <= r_sum + SUMW'(n_joint);
                CMD_PREP: begin
                    r_p0 <= (r_sum >= SUMW'(ONE_Q16)) ? '0 : 17'(SUMW'(ONE_Q16) - r_sum);
                    r_ph <= (r_sum > SUMW'(ONE_Q16)) ? ONE_Q16 : r_sum[16:0];
                    r_zm <= (r_sum >= SUMW'(ONE_Q16)) || (r_sum == '0);
                    r_acc_m <= '0;
                    r_acc_h <= '0;
                end
                CMD_EMIT: begin
                    r_acc_m <= n_tm;
                    r_acc_h <= n_th;
                    o_valid <= 1'b1;
                    o_hyp_index <= i_ctl.idx;
                    o_posterior_miss <= n_pm;
                    o_posterior_hit  <= n_pt;
                    o_prob_miss <= r_p0;
                    o_prob_hit  <= r_ph;
                    o_zero_mass <= r_zm;
                    o_last_result <= i_ctl.last;
                end
                CMD_CLEAR: r_sum <= '0;
                default: ;
            endcase
        end
    end

    // Entropy outputs only with the last result; sum includes that result's term.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == CMD_EMIT) begin
            o_entropy_miss <= !i_ctl.last ? '0 :
                ((n_tm > SUMW'(ENTROPY_MAX)) ? ENTROPY_MAX : n_tm[18:0]);
            o_entropy_hit  <= !i_ctl.last ? '0 :
                ((n_th > SUMW'(ENTROPY_MAX)) ? ENTROPY_MAX : n_th[18:0]);
        end
    end
    logic unused;
    assign unused = dm_done;
endmodule
`default_nettype wire

### rtl/bspe_ctrl.sv
// Controller: load sequencing, then per-hypothesis divide and emit.
// Depends on bspe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bspe_ctrl
    import bspe_pkg::*;
#(
    parameter int MAX_HYPOTHESES = MAX_HYP_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire logic i_last,
    input  wire t_sts i_sts,
    output logic      o_busy,
    output t_ctl      o_ctl
);
    typedef enum logic [2:0] {S_LOAD, S_PREP, S_READ, S_DIV, S_WAIT, S_EMIT, S_GAP} t_state;
    t_state     r_state;
    logic [6:0] r_cnt, r_n;
    logic [5:0] r_k;
    logic       n_acc;

    assign n_acc  = i_start && !o_busy;
    assign o_busy = (r_state != S_LOAD);

    always_comb begin
        o_ctl = '{cmd: CMD_NONE, idx: r_k, last: 1'b0};
        case (r_state)
            S_LOAD: if (n_acc && r_cnt < 7'(MAX_HYPOTHESES)) begin
                o_ctl.cmd = CMD_LOAD;
                o_ctl.idx = r_cnt[5:0];
            end
            S_PREP: o_ctl.cmd = CMD_PREP;
            S_DIV:  o_ctl.cmd = CMD_DIV_START;
            S_EMIT: begin
                o_ctl.cmd = CMD_EMIT;
                o_ctl.last = (7'(r_k) + 7'd1 == r_n);
            end
            S_GAP:  o_ctl.cmd = CMD_CLEAR;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= '0;
            r_n <= '0;
            r_k <= '0;
        end else begin
            case (r_state)
                S_LOAD: if (n_acc) begin
                    if (r_cnt < 7'(MAX_HYPOTHESES)) r_cnt <= r_cnt + 7'd1;
                    if (i_last) r_state <= S_PREP;
                end
                S_PREP: begin
                    r_n <= r_cnt;
                    r_k <= '0;
                    r_state <= (r_cnt == '0) ? S_GAP : S_READ;
                end
                S_READ: r_state <= S_DIV;
                S_DIV:  r_state <= S_WAIT;
                S_WAIT: if (i_sts.div_done) r_state <= S_EMIT;
                S_EMIT: begin
                    r_k <= r_k + 6'd1;
                    r_state <= (7'(r_k) + 7'd1 == r_n) ? S_GAP : S_READ;
                end
                S_GAP: begin
                    r_cnt <= '0;
                    r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/bspe_checker.sv
// Port-level checker for the posterior/entropy block, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bspe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [16:0] o_posterior_miss,
    input wire logic [16:0] o_posterior_hit,
    input wire logic [18:0] o_entropy_miss,
    input wire logic        o_zero_mass,
    input wire logic        o_last_result
);
    `ASSERT_CLK(a_valid_busy, i_clk, i_rst_n, o_valid |-> busy, "result while idle")
    `ASSERT_CLK(a_pm_range, i_clk, i_rst_n, o_valid |-> o_posterior_miss <= 17'd65536, "pm range")
    `ASSERT_CLK(a_ph_range, i_clk, i_rst_n, o_valid |-> o_posterior_hit <= 17'd65536, "ph range")
    `ASSERT_CLK(a_ent_last, i_clk, i_rst_n, (o_valid && !o_last_result) |-> o_entropy_miss == '0, "entropy early")
    `ASSERT_CLK(a_zm_miss, i_clk, i_rst_n, o_valid |-> o_zero_mass || o_posterior_miss <= 17'd65536, "zm")
endmodule
bind binary_split_posterior_entropy bspe_checker u_chk (.*);
`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for binary_split_posterior_entropy: directed and random
// hypothesis sets through the start/busy port, results predicted in-bench and compared.
// Depends on bspe_pkg and the binary_split_posterior_entropy RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import bspe_pkg::*;

    localparam int NHYP      = 16;
    localparam int TBITS     = 8;
    localparam int IDLE_MAX  = 3000;
    localparam int DRAIN_CYC = 100;

    typedef struct {
        logic [16:0] prior;
        logic [16:0] psi;
        logic        last;
    } t_hyp;

    typedef struct {
        logic [5:0]  idx;
        logic [16:0] pmiss;
        logic [16:0] phit;
        logic [16:0] p0;
        logic [16:0] p1;
        logic [18:0] hmiss;
        logic [18:0] hhit;
        logic        zm;
        logic        last;
    } t_post;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [16:0] i_prior_prob;
    logic [16:0] i_hit_likelihood;
    logic        i_last_hypothesis;
    logic        o_valid;
    logic [5:0]  o_hyp_index;
    logic [16:0] o_posterior_miss;
    logic [16:0] o_posterior_hit;
    logic [16:0] o_prob_miss;
    logic [16:0] o_prob_hit;
    logic [18:0] o_entropy_miss;
    logic [18:0] o_entropy_hit;
    logic        o_zero_mass;
    logic        o_last_result;

    binary_split_posterior_entropy dut (.*);

    t_hyp  hyp_queue[$];
    t_post posterior_queue[$];
    int    n_errors;
    int    idle_cycles;
    int    burst_left;
    int    gap_left;

    // predictor state
    logic [15:0] log2_lut[1 << TBITS];
    logic [16:0] prior_mem[NHYP];
    logic [16:0] joint_mem[NHYP];
    int          n_loaded;
    logic [23:0] joint_total;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [16:0] clip_one(logic [63:0] v);
        return (v > 64'd65536) ? 17'd65536 : v[16:0];
    endfunction

    function automatic logic [23:0] ent_term(logic [16:0] x);
        int          b;
        logic [63:0] f, idx, nlog;
        if (x == 0) return '0;
        b = 0;
        while (b < 16 && (x >> (b + 1)) != 0) b++;
        f = x - (64'd1 << b);
        idx = (b >= TBITS) ? (f >> (b - TBITS)) : (f << (TBITS - b));
        idx &= (64'd1 << TBITS) - 1;
        nlog = 64'(16 - b) * 64'd65536 - 64'(log2_lut[idx]);
        return 24'((64'(x) * nlog) >> 16);
    endfunction

    // Absorb one accepted hypothesis; on the last one, queue the posteriors.
    task automatic absorb_hypothesis(t_hyp h);
        logic [16:0] pr, ps, jn, num, pm, pt, p0, ph;
        logic [23:0] p1, acc_m, acc_h;
        logic [63:0] prod;
        logic        zm;
        t_post       r;
        pr = clip_one(64'(h.prior));
        ps = clip_one(64'(h.psi));
        if (n_loaded < NHYP) begin
            prod = (64'(ps) * 64'(pr) + 64'd32768) >> 16;
            jn = (prod > 64'(pr)) ? pr : prod[16:0];
            prior_mem[n_loaded] = pr;
            joint_mem[n_loaded] = jn;
            joint_total = joint_total + 24'(jn);
            n_loaded++;
        end
        if (!h.last) return;
        p1 = joint_total;
        p0 = (p1 >= 24'd65536) ? 17'd0 : 17'(24'd65536 - p1);
        ph = clip_one(64'(p1));
        zm = (p0 == 0) || (p1 == 0);
        acc_m = '0;
        acc_h = '0;
        for (int k = 0; k < n_loaded; k++) begin
            num = (prior_mem[k] >= joint_mem[k]) ? prior_mem[k] - joint_mem[k] : 17'd0;
            pm = (p0 != 0) ? clip_one((64'(num) << 16) / 64'(p0)) : 17'd0;
            pt = (p1 != 0) ? clip_one((64'(joint_mem[k]) << 16) / 64'(p1)) : 17'd0;
            acc_m = acc_m + ent_term(pm);
            acc_h = acc_h + ent_term(pt);
            r.idx   = 6'(k);
            r.pmiss = pm;
            r.phit  = pt;
            r.p0    = p0;
            r.p1    = ph;
            r.zm    = zm;
            r.last  = (k == n_loaded - 1);
            r.hmiss = r.last ? ((acc_m > 24'(ENTROPY_MAX)) ? ENTROPY_MAX : acc_m[18:0]) : '0;
            r.hhit  = r.last ? ((acc_h > 24'(ENTROPY_MAX)) ? ENTROPY_MAX : acc_h[18:0]) : '0;
            posterior_queue.push_back(r);
        end
        n_loaded = 0;
        joint_total = '0;
    endtask

    task automatic push_hyp(int pr, int ps, bit lst);
        t_hyp h;
        h.prior = 17'(pr);
        h.psi   = 17'(ps);
        h.last  = lst;
        hyp_queue.push_back(h);
    endtask

    // stimulus
    initial begin
        int n, total, cap;
        logic [63:0] z;
        logic [15:0] r;
        for (int i = 0; i < (1 << TBITS); i++) begin
            z = (64'(1 << TBITS) + 64'(i)) << (30 - TBITS);
            r = '0;
            for (int k = 0; k < 16; k++) begin
                z = (z * z) >> 30;
                r = {r[14:0], 1'b0};
                if (z >= 64'h8000_0000) begin
                    r[0] = 1'b1;
                    z = z >> 1;
                end
            end
            log2_lut[i] = r;
        end
        n_loaded = 0;
        joint_total = '0;

        // certain hit: p0 is zero
        push_hyp(65536, 65536, 1);
        // no hit mass at all
        push_hyp(30000, 0, 0);
        push_hyp(35536, 0, 1);
        // hit mass above one
        push_hyp(65536, 65536, 0);
        push_hyp(65536, 60000, 0);
        push_hyp(40000, 65536, 1);
        // out-of-range inputs saturate, zero prior gives a zero term
        push_hyp(131071, 131071, 0);
        push_hyp(0, 32768, 0);
        push_hyp(1, 1, 1);
        // overflow set: last item is dropped but still closes the set
        for (int i = 0; i < 17; i++)
            push_hyp(3000 + i * 37, 20000 + i * 2000, i == 16);

        total = 0;
        while (total < 400) begin
            n = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 16) : $urandom_range(17, 20);
            cap = 131072 / n;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0)
                    push_hyp($urandom_range(0, 131071), $urandom_range(0, 131071), i == n - 1);
                else
                    push_hyp($urandom_range(0, cap), $urandom_range(0, 65536), i == n - 1);
            end
            total += n;
        end
    end

    // driver: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_prior_prob <= '0;
            i_hit_likelihood <= '0;
            i_last_hypothesis <= 1'b0;
            burst_left <= 4;
            gap_left <= 0;
        end else if (start && !busy) begin
            absorb_hypothesis(hyp_queue.pop_front());
            if (burst_left <= 1 && $urandom_range(0, 9) < 7) begin
                start <= 1'b0;
                gap_left <= $urandom_range(1, 12);
                burst_left <= $urandom_range(1, 24);
            end else begin
                burst_left <= burst_left - 1;
                if (hyp_queue.size() > 0) begin
                    i_prior_prob <= hyp_queue[0].prior;
                    i_hit_likelihood <= hyp_queue[0].psi;
                    i_last_hypothesis <= hyp_queue[0].last;
                end else begin
                    start <= 1'b0;
                end
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (hyp_queue.size() > 0) begin
                start <= 1'b1;
                i_prior_prob <= hyp_queue[0].prior;
                i_hit_likelihood <= hyp_queue[0].psi;
                i_last_hypothesis <= hyp_queue[0].last;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_post e;
        if (i_rst_n && o_valid) begin
            if (posterior_queue.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result idx=%0d", o_hyp_index);
            end else begin
                e = posterior_queue.pop_front();
                if (o_hyp_index !== e.idx || o_posterior_miss !== e.pmiss
                        || o_posterior_hit !== e.phit || o_prob_miss !== e.p0
                        || o_prob_hit !== e.p1 || o_entropy_miss !== e.hmiss
                        || o_entropy_hit !== e.hhit || o_zero_mass !== e.zm
                        || o_last_result !== e.last) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch exp idx=%0d pm=%0d ph=%0d p0=%0d p1=%0d hm=%0d hh=%0d zm=%0b l=%0b",
                                 e.idx, e.pmiss, e.phit, e.p0, e.p1, e.hmiss, e.hhit, e.zm, e.last);
                        $display("         got idx=%0d pm=%0d ph=%0d p0=%0d p1=%0d hm=%0d hh=%0d zm=%0b l=%0b",
                                 o_hyp_index, o_posterior_miss, o_posterior_hit, o_prob_miss,
                                 o_prob_hit, o_entropy_miss, o_entropy_hit, o_zero_mass,
                                 o_last_result);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("binary_split_posterior_entropy regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        n_errors = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_prior_prob = '0;
        i_hit_likelihood = '0;
        i_last_hypothesis = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (hyp_queue.size() == 0 && !start);
        wait (posterior_queue.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0 && posterior_queue.size() == 0)
            $display("binary_split_posterior_entropy regression: pass");
        else
            $display("binary_split_posterior_entropy regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
